>>> src/skcd_pkg.sv
package skcd_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_PROCESS_NOISE     = 3'd0;
  localparam logic [2:0] CFG_OBS_GAIN          = 3'd1;
  localparam logic [2:0] CFG_TRANSITION        = 3'd2;
  localparam logic [2:0] CFG_MEAS_NOISE        = 3'd3;
  localparam logic [2:0] CFG_WINDOW_LEN        = 3'd4;
  localparam logic [2:0] CFG_RECOMPUTE_GAP     = 3'd5;
  localparam logic [2:0] CFG_MIN_NOISE_VAR     = 3'd6;
  localparam logic [2:0] CFG_INITIAL_STATISTIC = 3'd7;

  // divider geometry: numerator is left aligned in DIV_NUM_W bits
  localparam int DIV_NUM_W = 80;
  localparam int DIV_CNT_W = 7;

  // ln(2) in q16.16
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  // request word to the shared divider
  typedef struct packed {
    logic                   start;
    logic [DIV_NUM_W-1:0]   num;
    logic [31:0]            den;
    logic [DIV_CNT_W-1:0]   iters;
  } div_req_t;

  // ln(1 + i/16) in q16.16, 17 points
  function automatic logic [15:0] ln_point(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:    r = 16'd0;
      5'd1:    r = 16'd3973;
      5'd2:    r = 16'd7719;
      5'd3:    r = 16'd11262;
      5'd4:    r = 16'd14624;
      5'd5:    r = 16'd17821;
      5'd6:    r = 16'd20870;
      5'd7:    r = 16'd23783;
      5'd8:    r = 16'd26573;
      5'd9:    r = 16'd29248;
      5'd10:   r = 16'd31818;
      5'd11:   r = 16'd34292;
      5'd12:   r = 16'd36675;
      5'd13:   r = 16'd38975;
      5'd14:   r = 16'd41196;
      5'd15:   r = 16'd43345;
      5'd16:   r = 16'd45426;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // clip an unsigned 64 bit value to 32 bits
  function automatic logic [31:0] sat_u32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // clip a signed 33 bit value to 32 bits
  function automatic logic signed [31:0] sat_s33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // signed q16 product from a magnitude product and the sign
  function automatic logic signed [31:0] smul_sat(input logic [63:0] prod, input logic neg);
    logic [47:0]        m;
    logic signed [31:0] r;
    m = prod[63:16];
    if (!neg) begin
      r = (|m[47:31]) ? 32'sh7FFF_FFFF : $signed({1'b0, m[30:0]});
    end else begin
      r = (m > 48'h0000_8000_0000) ? 32'sh8000_0000 : $signed(32'(48'd0 - m));
    end
    return r;
  endfunction

  // magnitude of a signed 32 bit word
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // magnitude of a signed 16 bit word
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? (16'd0 - v) : v;
  endfunction

endpackage

>>> src/scalar_kalman_cusum_detector.sv
// Scalar AR(1) Kalman filter with a likelihood CUSUM. Each sample word runs one
// predict/update step on a single shared 32x32 multiplier and a shared divider that
// yields one quotient bit per cycle, under a one-hot sequencer; the block takes no new
// word until the current one is finished. A normal word passes through five divisions
// (of 64, 64, 80, 34 and 64 quotient bits), the other sequencer steps and the ln
// normalising shift, which shifts until the top bit is set; a stalled result holds
// the block until it is taken. When the noise variance is re-estimated, the word
// first makes a pass over the newest n+1 samples of the window, then forms the
// normalisation products and runs the 48 step variance division. The first word
// after reset only primes the window and goes straight to the done step, which
// returns the initial statistic. Configuration may be written at any time the
// block is idle; cfg_ready is always high.
module scalar_kalman_cusum_detector
  import skcd_pkg::*;
#(
  parameter int MAX_WINDOW  = 255,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_statistic,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int RING_DEPTH = MAX_WINDOW + 1;
  localparam int AW         = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [33:0] {
    ST_IDLE  = 34'h0_0000_0001,
    ST_WRD   = 34'h0_0000_0002,
    ST_WMUL  = 34'h0_0000_0004,
    ST_WACC  = 34'h0_0000_0008,
    ST_WN1   = 34'h0_0000_0010,
    ST_WN2   = 34'h0_0000_0020,
    ST_WN3   = 34'h0_0000_0040,
    ST_WN4   = 34'h0_0000_0080,
    ST_WN5   = 34'h0_0000_0100,
    ST_WVAR  = 34'h0_0000_0200,
    ST_FX1   = 34'h0_0000_0400,
    ST_FF2   = 34'h0_0000_0800,
    ST_FP1A  = 34'h0_0000_1000,
    ST_FP1B  = 34'h0_0000_2000,
    ST_FSV   = 34'h0_0000_4000,
    ST_FSVB  = 34'h0_0000_8000,
    ST_FE    = 34'h0_0001_0000,
    ST_FK    = 34'h0_0002_0000,
    ST_FK2   = 34'h0_0004_0000,
    ST_FQ1   = 34'h0_0008_0000,
    ST_FT2   = 34'h0_0010_0000,
    ST_FT3   = 34'h0_0020_0000,
    ST_FT3B  = 34'h0_0040_0000,
    ST_FT3C  = 34'h0_0080_0000,
    ST_FX    = 34'h0_0100_0000,
    ST_FP    = 34'h0_0200_0000,
    ST_FPN   = 34'h0_0400_0000,
    ST_LNORM = 34'h0_0800_0000,
    ST_LMUL  = 34'h0_1000_0000,
    ST_LSUM  = 34'h0_2000_0000,
    ST_FST   = 34'h0_4000_0000,
    ST_FACC  = 34'h0_8000_0000,
    ST_DONE  = 34'h1_0000_0000,
    ST_DWAIT = 34'h2_0000_0000
  } state_t;

  state_t state_r, state_nxt, ret_r;

  // configuration registers
  logic [31:0]        cfg_q_r;
  logic signed [31:0] cfg_h_r;
  logic signed [31:0] cfg_f_r;
  logic [31:0]        cfg_r_r;
  logic [7:0]         cfg_wlen_r;
  logic [15:0]        cfg_gap_r;
  logic [31:0]        cfg_vmin_r;
  logic [31:0]        cfg_init_r;

  // filter and window state
  logic [AW-1:0]      ptr_r;
  logic [15:0]        cnt_r;
  logic [15:0]        gap_r;
  logic [31:0]        v_r;
  logic signed [31:0] x_r;
  logic [31:0]        p_r;
  logic [31:0]        acc_r;

  // per word working registers
  logic signed [15:0] s_r;
  logic [7:0]         n_r;
  logic [7:0]         i_r;
  logic [AW-1:0]      rd_ptr_r;
  logic signed [23:0] wsum_r;
  logic [39:0]        wsq_r;
  logic [47:0]        num_r;
  logic signed [31:0] x1_r;
  logic [31:0]        p1_r;
  logic [31:0]        sv_r;
  logic signed [31:0] e_r;
  logic [30:0]        kmag_r;
  logic               kneg_r;
  logic [40:0]        t2_r;
  logic [32:0]        t3_r;
  logic [31:0]        norm_r;
  logic [4:0]         lp_r;
  logic signed [21:0] ln_r;
  logic signed [42:0] st_r;
  logic               res_sat_r;

  // output word
  logic               out_valid_r;
  logic [31:0]        out_stat_r;
  logic               out_sat_r;

  // shared units
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_p;
  div_req_t             div_req;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  logic signed [15:0] rd_data;
  logic signed [15:0] s_conv;
  logic               accept;
  logic [7:0]         wl_eff;
  logic [7:0]         n_eff;
  logic [31:0]        r_eff;
  logic [31:0]        vmin_eff;
  logic [8:0]         m_w;
  logic [AW-1:0]      ptr_inc;
  logic [AW-1:0]      rd_ptr_dec;
  logic signed [32:0] z_w;
  logic [47:0]        var_w;
  logic [4:0]         ln_idx;
  logic [11:0]        ln_rem;
  logic [15:0]        ln_diff;
  logic signed [6:0]  lp_s;
  logic signed [21:0] ln_w;
  logic [43:0]        sum_w;

  // sample conversion to q1.15
  generate
    if (SAMPLE_BITS > 16) begin : g_wide
      assign s_conv = 16'(in_sample >>> (SAMPLE_BITS - 16));
    end else begin : g_narrow
      assign s_conv = 16'(in_sample) <<< (16 - SAMPLE_BITS);
    end
  endgenerate

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective register values
  assign wl_eff   = (cfg_wlen_r == 8'd0) ? 8'd1 : cfg_wlen_r;
  assign n_eff    = (32'(wl_eff) > MAX_WINDOW) ? 8'(MAX_WINDOW) : wl_eff;
  assign r_eff    = (cfg_r_r == 32'd0) ? 32'd1 : cfg_r_r;
  assign vmin_eff = (cfg_vmin_r == 32'd0) ? 32'd1 : cfg_vmin_r;
  assign m_w      = {1'b0, n_r} + 9'd1;

  assign ptr_inc    = (ptr_r == AW'(MAX_WINDOW)) ? '0 : ptr_r + 1'b1;
  assign rd_ptr_dec = (rd_ptr_r == '0) ? AW'(MAX_WINDOW) : rd_ptr_r - 1'b1;

  assign z_w   = 33'($signed({s_r, 1'b0}));
  assign var_w = div_quot[47:0];

  // ln interpolation fields
  assign ln_idx  = {1'b0, norm_r[30:27]};
  assign ln_rem  = norm_r[26:15];
  assign ln_diff = ln_point(ln_idx + 5'd1) - ln_point(ln_idx);
  assign lp_s    = $signed({2'b00, lp_r}) - 7'sd16;
  assign ln_w    = 22'(lp_s) * $signed({6'b0, LN2_Q16})
                 + $signed({6'b0, ln_point(ln_idx)})
                 + $signed({10'b0, mul_p[23:12]});

  assign sum_w = {12'b0, acc_r} + {1'b0, st_r};

  skcd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  skcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  skcd_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ptr_r),
    .wr_data (s_conv),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  // multiplier operands and divider requests per step
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = sv_r;
    div_req.iters = DIV_CNT_W'(64);
    case (state_r)
      ST_WMUL: begin
        mul_a = 32'(mag16(rd_data));
        mul_b = 32'(mag16(rd_data));
      end
      ST_WN1: begin
        mul_a = 32'(m_w);
        mul_b = wsq_r[31:0];
      end
      ST_WN2: begin
        mul_a = 32'(m_w);
        mul_b = 32'(wsq_r[39:32]);
      end
      ST_WN3: begin
        mul_a = 32'(mag32(32'(wsum_r)));
        mul_b = 32'(mag32(32'(wsum_r)));
      end
      ST_WN4: begin
        mul_a = 32'(m_w);
        mul_b = 32'(n_r);
      end
      ST_WN5: begin
        div_req.start = 1'b1;
        div_req.num   = {num_r, 32'b0};
        div_req.den   = {mul_p[17:0], 14'b0};
        div_req.iters = DIV_CNT_W'(48);
      end
      ST_FX1: begin
        mul_a = mag32(cfg_f_r);
        mul_b = mag32(x_r);
      end
      ST_FF2: begin
        mul_a = mag32(cfg_f_r);
        mul_b = mag32(cfg_f_r);
      end
      ST_FP1A: begin
        mul_a = sat_u32(mul_p >> 16);
        mul_b = p_r;
      end
      ST_FP1B: begin
        mul_a = mag32(cfg_h_r);
        mul_b = mag32(cfg_h_r);
      end
      ST_FSV: begin
        mul_a = sat_u32(mul_p >> 16);
        mul_b = p1_r;
      end
      ST_FSVB: begin
        mul_a = mag32(cfg_h_r);
        mul_b = mag32(x1_r);
      end
      ST_FE: begin
        mul_a = p1_r;
        mul_b = mag32(cfg_h_r);
      end
      ST_FK, ST_FQ1, ST_FP: begin
        div_req.start = 1'b1;
        div_req.num   = {mul_p, 16'b0};
      end
      ST_FK2: begin
        mul_a = mag32(e_r);
        mul_b = mag32(e_r);
      end
      ST_FT2: begin
        div_req.start = 1'b1;
        div_req.num   = {div_quot[63:0], 16'b0};
        div_req.den   = v_r;
        div_req.iters = DIV_CNT_W'(80);
      end
      ST_FT3: begin
        mul_a = 32'(mag16(s_r));
        mul_b = 32'(mag16(s_r));
      end
      ST_FT3B: begin
        div_req.start = 1'b1;
        div_req.num   = {mul_p[31:0], 2'b0, 46'b0};
        div_req.den   = v_r;
        div_req.iters = DIV_CNT_W'(34);
      end
      ST_FT3C: begin
        mul_a = {1'b0, kmag_r};
        mul_b = mag32(e_r);
      end
      ST_FX: begin
        mul_a = p1_r;
        mul_b = r_eff;
      end
      ST_LMUL: begin
        mul_a = 32'(ln_diff);
        mul_b = 32'(ln_rem);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_r == 16'd0) begin
            state_nxt = ST_DONE;
          end else if (cnt_r > {8'b0, n_eff} && gap_r > cfg_gap_r) begin
            state_nxt = ST_WRD;
          end else begin
            state_nxt = ST_FX1;
          end
        end
      end
      ST_WRD:   state_nxt = ST_WMUL;
      ST_WMUL:  state_nxt = ST_WACC;
      ST_WACC:  state_nxt = (i_r == n_r) ? ST_WN1 : ST_WRD;
      ST_WN1:   state_nxt = ST_WN2;
      ST_WN2:   state_nxt = ST_WN3;
      ST_WN3:   state_nxt = ST_WN4;
      ST_WN4:   state_nxt = ST_WN5;
      ST_WN5:   state_nxt = ST_DWAIT;
      ST_WVAR:  state_nxt = ST_FX1;
      ST_FX1:   state_nxt = ST_FF2;
      ST_FF2:   state_nxt = ST_FP1A;
      ST_FP1A:  state_nxt = ST_FP1B;
      ST_FP1B:  state_nxt = ST_FSV;
      ST_FSV:   state_nxt = ST_FSVB;
      ST_FSVB:  state_nxt = ST_FE;
      ST_FE:    state_nxt = ST_FK;
      ST_FK:    state_nxt = ST_DWAIT;
      ST_FK2:   state_nxt = ST_FQ1;
      ST_FQ1:   state_nxt = ST_DWAIT;
      ST_FT2:   state_nxt = ST_DWAIT;
      ST_FT3:   state_nxt = ST_FT3B;
      ST_FT3B:  state_nxt = ST_DWAIT;
      ST_FT3C:  state_nxt = ST_FX;
      ST_FX:    state_nxt = ST_FP;
      ST_FP:    state_nxt = ST_DWAIT;
      ST_FPN:   state_nxt = ST_LNORM;
      ST_LNORM: state_nxt = norm_r[31] ? ST_LMUL : ST_LNORM;
      ST_LMUL:  state_nxt = ST_LSUM;
      ST_LSUM:  state_nxt = ST_FST;
      ST_FST:   state_nxt = ST_FACC;
      ST_FACC:  state_nxt = ST_DONE;
      ST_DONE:  state_nxt = (!out_valid_r || !out_stall) ? ST_IDLE : ST_DONE;
      ST_DWAIT: state_nxt = div_done ? ret_r : ST_DWAIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and state registers; the sample store is only read where written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      cfg_q_r     <= 32'h0001_0000;
      cfg_h_r     <= 32'sh0001_0000;
      cfg_f_r     <= 32'sh0001_0000;
      cfg_r_r     <= 32'h0001_0000;
      cfg_wlen_r  <= 8'd64;
      cfg_gap_r   <= 16'd32;
      cfg_vmin_r  <= 32'd1;
      cfg_init_r  <= 32'd0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      gap_r       <= '0;
      v_r         <= 32'h0001_0000;
      x_r         <= '0;
      p_r         <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:     cfg_q_r    <= cfg_data;
          CFG_OBS_GAIN:          cfg_h_r    <= cfg_data;
          CFG_TRANSITION:        cfg_f_r    <= cfg_data;
          CFG_MEAS_NOISE:        cfg_r_r    <= cfg_data;
          CFG_WINDOW_LEN:        cfg_wlen_r <= cfg_data[7:0];
          CFG_RECOMPUTE_GAP:     cfg_gap_r  <= cfg_data[15:0];
          CFG_MIN_NOISE_VAR:     cfg_vmin_r <= cfg_data;
          CFG_INITIAL_STATISTIC: cfg_init_r <= cfg_data;
          default:               cfg_q_r    <= cfg_q_r;
        endcase
      end

      // result taken and no new word loaded this cycle
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        // take a word, store the sample, decide the path
        ST_IDLE: begin
          if (accept) begin
            s_r   <= s_conv;
            ptr_r <= ptr_inc;
            n_r   <= n_eff;
            if (cnt_r != 16'hFFFF) begin
              cnt_r <= cnt_r + 16'd1;
            end
            if (cnt_r == 16'd0) begin
              acc_r     <= cfg_init_r;
              res_sat_r <= 1'b0;
            end else if (cnt_r > {8'b0, n_eff} && gap_r > cfg_gap_r) begin
              gap_r    <= 16'd1;
              i_r      <= '0;
              wsum_r   <= '0;
              wsq_r    <= '0;
              rd_ptr_r <= ptr_r;
            end else if (gap_r != 16'hFFFF) begin
              gap_r <= gap_r + 16'd1;
            end
          end
        end
        // window pass, newest sample first
        ST_WMUL: wsum_r <= wsum_r + 24'(rd_data);
        ST_WACC: begin
          wsq_r    <= wsq_r + mul_p[39:0];
          rd_ptr_r <= rd_ptr_dec;
          i_r      <= i_r + 8'd1;
        end
        ST_WN2: num_r <= mul_p[47:0];
        ST_WN3: num_r <= num_r + {mul_p[15:0], 32'b0};
        ST_WN4: num_r <= num_r - mul_p[47:0];
        ST_WN5: ret_r <= ST_WVAR;
        ST_WVAR: begin
          if (var_w < 48'(vmin_eff)) begin
            v_r <= vmin_eff;
          end else begin
            v_r <= sat_u32(64'(var_w));
          end
        end
        // predict and innovation
        ST_FF2:  x1_r <= smul_sat(mul_p, cfg_f_r[31] ^ x_r[31]);
        ST_FP1B: p1_r <= sat_u32(64'(sat_u32(mul_p >> 16)) + 64'(cfg_q_r));
        ST_FSVB: sv_r <= sat_u32(64'(sat_u32(mul_p >> 16)) + 64'(r_eff));
        ST_FE:   e_r  <= sat_s33(z_w - 33'(smul_sat(mul_p, cfg_h_r[31] ^ x1_r[31])));
        ST_FK:   ret_r <= ST_FK2;
        ST_FK2: begin
          kmag_r <= (div_quot[63:31] != '0) ? 31'h7FFF_FFFF : div_quot[30:0];
          kneg_r <= cfg_h_r[31];
        end
        ST_FQ1: ret_r <= ST_FT2;
        ST_FT2: ret_r <= ST_FT3;
        ST_FT3: begin
          if (div_quot > DIV_NUM_W'(41'h100_0000_0000)) begin
            t2_r <= 41'h100_0000_0000;
          end else begin
            t2_r <= div_quot[40:0];
          end
        end
        ST_FT3B: ret_r <= ST_FT3C;
        ST_FT3C: t3_r  <= div_quot[32:0];
        // update
        ST_FX: x_r   <= sat_s33(33'(x1_r) + 33'(smul_sat(mul_p, kneg_r ^ e_r[31])));
        ST_FP: ret_r <= ST_FPN;
        ST_FPN: begin
          p_r    <= div_quot[31:0];
          norm_r <= sv_r;
          lp_r   <= 5'd31;
        end
        // ln normalising shift
        ST_LNORM: begin
          if (!norm_r[31]) begin
            norm_r <= {norm_r[30:0], 1'b0};
            lp_r   <= lp_r - 5'd1;
          end
        end
        ST_LSUM: ln_r <= ln_w;
        ST_FST:  st_r <= $signed({10'b0, t3_r}) - $signed({2'b0, t2_r}) - 43'(ln_r);
        // cusum accumulate with clipping
        ST_FACC: begin
          if (st_r[42]) begin
            acc_r     <= '0;
            res_sat_r <= 1'b0;
          end else if (|sum_w[43:32]) begin
            acc_r     <= 32'hFFFF_FFFF;
            res_sat_r <= 1'b1;
          end else begin
            acc_r     <= sum_w[31:0];
            res_sat_r <= 1'b0;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_stat_r  <= acc_r;
            out_sat_r   <= res_sat_r;
          end
        end
        default: begin
          lp_r <= lp_r;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_statistic = out_stat_r;
  assign out_saturated = out_sat_r;

  // divider only finishes while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DWAIT)
    else $error("divider finished outside its wait step");

  // a clipped word always carries the top value
  a_sat_means_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_statistic == 32'hFFFF_FFFF)
    else $error("saturated flag without clipped statistic");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // noise variance never reaches zero
  a_var_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r != 32'd0)
    else $error("noise variance is zero");

endmodule

>>> src/skcd_mul.sv
module skcd_mul
  import skcd_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  logic [63:0] p_r;

  // one registered unsigned product per cycle
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

  assign p = p_r;

endmodule

>>> src/skcd_div.sv
module skcd_div
  import skcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  logic [DIV_NUM_W-1:0] q_r;
  logic [31:0]          rem_r;
  logic [31:0]          den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [32:0]          rem_sh;
  logic                 fits;

  // restoring step, one quotient bit per cycle
  assign rem_sh = {rem_r, q_r[DIV_NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= req.iters;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
        q_r   <= {q_r[DIV_NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> src/skcd_ring.sv
module skcd_ring
  import skcd_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [15:0]  wr_data,
  input  logic [AW-1:0]       rd_addr,
  output logic signed [15:0]  rd_data
);

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_data_r;

  // sample store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/scalar_kalman_cusum_detector_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_cusum_detector_tb;
  import skcd_pkg::*;

  typedef struct {
    logic [31:0] statistic;
    logic        saturated;
  } cusum_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_statistic;
  logic               out_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = CFG_PROCESS_NOISE;
  logic [31:0]        cfg_data = '0;

  scalar_kalman_cusum_detector uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_statistic(out_statistic), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ln(1 + i/16) points in q16.16
  localparam longint LN_PTS [0:16] = '{0, 3973, 7719, 11262, 14624, 17821, 20870,
    23783, 26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

  // register copies
  logic [31:0] q_noise, h_gain, f_trans, r_noise, v_floor, start_stat;
  logic [7:0]  win_len;
  logic [15:0] est_gap;

  // filter and window state
  logic signed [15:0] hist [0:255];
  int unsigned        hist_ptr, seen_cnt, gap_cnt;
  logic [31:0]        noise_v, p_cov, cusum;
  longint             x_est;

  logic signed [15:0] pending [$];
  cusum_word_t        results_due [$];
  int                 errors = 0;
  int                 send_gap = 0;
  int                 stall_left = 0;
  bit                 quiet = 1'b0;

  function automatic logic [63:0] mag64(input longint a);
    return 64'(a < 0 ? -a : a);
  endfunction

  function automatic longint clip_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] clip_u32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] uq_mul(input logic [63:0] a, input logic [63:0] b);
    return clip_u32((a * b) >> 16);
  endfunction

  function automatic longint sq_mul(input longint a, input longint b);
    logic [63:0] m;
    m = (mag64(a) * mag64(b)) >> 16;
    return clip_s32(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint ln_fix(input logic [31:0] s);
    int          p;
    logic [31:0] nrm, frac, idx, rem;
    p = 31;
    while (p > 0 && s[p] == 1'b0) p--;
    nrm  = s << (31 - p);
    frac = (nrm >> 15) & 32'hFFFF;
    idx  = frac >> 12;
    rem  = frac & 32'hFFF;
    return (longint'(p) - 16) * longint'(LN2_Q16) + LN_PTS[idx] +
           ((LN_PTS[idx+1] - LN_PTS[idx]) * longint'(rem)) / 4096;
  endfunction

  function automatic logic [63:0] cap_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, r, res;
    q = num / den;
    r = num % den;
    if (q >= 64'd16777216) return 64'd1 << 40;
    res = (q << 16) + ((r << 16) / den);
    return (res > (64'd1 << 40)) ? (64'd1 << 40) : res;
  endfunction

  // sample variance over the newest n+1 samples
  function automatic void refresh_noise(input int unsigned n);
    longint      wsum;
    logic [63:0] wsq, num, var_v, fl, m;
    int unsigned idx;
    wsum = 0;
    wsq  = 0;
    m    = 64'(n) + 64'd1;
    for (int unsigned i = 0; i < n + 1; i++) begin
      idx  = (hist_ptr + 255 - i) % 256;
      wsum += longint'(hist[idx]);
      wsq  += 64'(longint'(hist[idx]) * longint'(hist[idx]));
    end
    num   = m * wsq - mag64(wsum) * mag64(wsum);
    var_v = num / (m * 64'(n) * 64'd16384);
    fl    = 64'((v_floor != 0) ? v_floor : 32'd1);
    if (var_v < fl) var_v = fl;
    noise_v = clip_u32(var_v);
  endfunction

  function automatic void clear_model();
    q_noise = 32'd65536; h_gain = 32'd65536; f_trans = 32'd65536;
    r_noise = 32'd65536; win_len = 8'd64; est_gap = 16'd32;
    v_floor = 32'd1; start_stat = 32'd0;
    for (int i = 0; i < 256; i++) hist[i] = '0;
    hist_ptr = 0; seen_cnt = 0; gap_cnt = 0; noise_v = 32'd65536;
    x_est = 0; p_cov = 0; cusum = 0;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      CFG_PROCESS_NOISE:     q_noise = val;
      CFG_OBS_GAIN:          h_gain = val;
      CFG_TRANSITION:        f_trans = val;
      CFG_MEAS_NOISE:        r_noise = val;
      CFG_WINDOW_LEN:        win_len = val[7:0];
      CFG_RECOMPUTE_GAP:     est_gap = val[15:0];
      CFG_MIN_NOISE_VAR:     v_floor = val;
      CFG_INITIAL_STATISTIC: start_stat = val;
      default: ;
    endcase
  endfunction

  // one predict/update step and cusum update
  function automatic cusum_word_t kalman_cusum_step(input logic signed [15:0] smp);
    cusum_word_t  w;
    longint       s, z, f, h, x1, e, k, st, ln_s;
    logic [31:0]  r, p1, sv, f2, h2;
    logic [63:0]  kmag, q1, t2, t3, sum;
    int unsigned  it, n;
    s = longint'(smp);
    hist[hist_ptr] = smp;
    hist_ptr = (hist_ptr + 1) % 256;
    it = seen_cnt;
    if (seen_cnt < 65535) seen_cnt++;
    w.saturated = 1'b0;
    if (it == 0) begin
      cusum = start_stat;
      w.statistic = cusum;
      return w;
    end
    n = (win_len == 0) ? 1 : win_len;
    if (it > n && gap_cnt > est_gap) begin
      refresh_noise(n);
      gap_cnt = 0;
    end
    if (gap_cnt < 65535) gap_cnt++;

    z = s * 2;
    f = longint'($signed(f_trans));
    h = longint'($signed(h_gain));
    r = (r_noise != 0) ? r_noise : 32'd1;

    x1   = sq_mul(f, x_est);
    f2   = uq_mul(mag64(f), mag64(f));
    p1   = clip_u32(64'(uq_mul(f2, p_cov)) + 64'(q_noise));
    h2   = uq_mul(mag64(h), mag64(h));
    sv   = clip_u32(64'(uq_mul(h2, p1)) + 64'(r));
    e    = clip_s32(z - sq_mul(h, x1));
    kmag = (64'(p1) * mag64(h)) / 64'(sv);
    if (kmag > 64'd2147483647) kmag = 64'd2147483647;
    k    = (h < 0) ? -longint'(kmag) : longint'(kmag);

    ln_s = ln_fix(sv);
    q1   = (mag64(e) * mag64(e)) / 64'(sv);
    t2   = cap_div(q1, 64'(noise_v));
    t3   = (64'(s * s) * 64'd4) / 64'(noise_v);
    st   = -ln_s - longint'(t2) + longint'(t3);

    x_est = clip_s32(x1 + sq_mul(k, e));
    p_cov = 32'((64'(p1) * 64'(r)) / 64'(sv));

    if (st < 0) begin
      cusum = 0;
    end else begin
      sum = 64'(cusum) + 64'(st);
      if (sum > 64'hFFFF_FFFF) begin
        sum = 64'hFFFF_FFFF;
        w.saturated = 1'b1;
      end
      cusum = sum[31:0];
    end
    w.statistic = cusum;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(kalman_cusum_step(in_sample));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_sample <= pending.pop_front();
          in_valid  <= 1'b1;
          send_gap  <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cusum_word_t want;
    int          d;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected word", out_statistic, 32'd0);
        end else begin
          want = results_due.pop_front();
          if (out_statistic !== want.statistic)
            report_mismatch("statistic", out_statistic, want.statistic);
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_saturated), 32'(want.saturated));
        end
        d = draw_wait();
        stall_left <= d;
        out_stall  <= (d != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall  <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] pn, input logic [31:0] h, input logic [31:0] f,
                           input logic [31:0] rn, input logic [31:0] wl, input logic [31:0] gp,
                           input logic [31:0] fl);
    write_reg(CFG_PROCESS_NOISE, pn);
    write_reg(CFG_OBS_GAIN, h);
    write_reg(CFG_TRANSITION, f);
    write_reg(CFG_MEAS_NOISE, rn);
    write_reg(CFG_WINDOW_LEN, wl);
    write_reg(CFG_RECOMPUTE_GAP, gp);
    write_reg(CFG_MIN_NOISE_VAR, fl);
    write_reg(CFG_INITIAL_STATISTIC, $urandom());
  endtask

  // random samples: steady runs with jitter, full range values and some extremes
  task automatic load_random(input int count);
    logic signed [15:0] base;
    int                 pick;
    base = 16'($urandom());
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) base = 16'($urandom());
      if (pick < 45) pending.push_back(base + $signed(16'($urandom_range(0, 6))) - 16'sd3);
      else if (pick < 85) pending.push_back(16'($urandom()));
      else if (pick < 90) pending.push_back(16'sh7FFF);
      else if (pick < 95) pending.push_back(16'sh8000);
      else pending.push_back(16'sh0000);
    end
  endtask

  // stimulus and phase control
  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: priming with a random start value, then extremes
    write_reg(CFG_INITIAL_STATISTIC, 32'h1234_5678);
    write_all(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd4, 32'd0, 32'd1);
    foreach (LN_PTS[i]) ;
    pending.push_back(16'sh7FFF);
    pending.push_back(16'sh8000);
    pending.push_back(16'sh0000);
    pending.push_back(16'sh0001);
    pending.push_back(16'shFFFF);
    for (int i = 0; i < 8; i++) pending.push_back(16'sh7FFF);
    for (int i = 0; i < 6; i++) pending.push_back(16'sh5555);
    pending.push_back(16'shAAAA);
    pending.push_back(16'sh0000);
    wait_idle();

    // zero noise, gap and floor registers, extreme gain and transition, and a zero window length
    write_all(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    pending.push_back(16'sh7FFF);
    pending.push_back(16'sh8000);
    pending.push_back(16'sh4000);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph % 4 == 3);
      case (ph)
        0: write_all(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd64, 32'd32, 32'd1);
        1: write_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'd255, 32'd0, 32'hFFFF_FFFF);
        2: write_all(32'd100, 32'hFFFF_0000, 32'd60000, 32'd1, 32'd1, 32'd65535, 32'd1);
        3: write_all(32'd3000, 32'd65536, 32'd58982, 32'd20000, 32'd8, 32'd2, 32'd1);
        4: write_all(32'd0, 32'd0, 32'd0, 32'd1, 32'd16, 32'd5, 32'd1);
        5: write_all(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd3, 32'd1, 32'd1000);
        default: write_all($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom_range(0, 32), $urandom_range(0, 40), $urandom());
      endcase
      load_random(ph == 1 ? 60 : 180);
      wait_idle();
    end

    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
